### hw/rtl/ccc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_pkg: shared types, constants and helpers for the chat command classifier
// Holds the parser state word, keyword text, token layouts and the
// end-of-text acceptance rule.
// ----------------------------------------------------------------------------
package ccc_pkg;

    // message kinds, also the verdict code
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_AUTH = 3'd1,
        KIND_MSG  = 3'd2,
        KIND_JOIN = 3'd3,
        KIND_ERR  = 3'd4,
        KIND_BYE  = 3'd5
    } kind_t;

    // keyword ids
    typedef enum logic [3:0] {
        KW_AUTH  = 4'd0,
        KW_AS    = 4'd1,
        KW_USING = 4'd2,
        KW_JOIN  = 4'd3,
        KW_MSG   = 4'd4,
        KW_FROM  = 4'd5,
        KW_IS    = 4'd6,
        KW_ERR   = 4'd7,
        KW_BYE   = 4'd8
    } kw_t;

    // token roles inside a command layout
    typedef enum logic [1:0] {
        TOK_KW    = 2'd0,
        TOK_PARAM = 2'd1,
        TOK_TAIL  = 2'd2
    } tok_ty_t;

    typedef struct packed {
        tok_ty_t    ty;
        logic [3:0] arg;   // keyword id or parameter number
    } tok_t;

    // parser state carried from byte to byte
    typedef struct packed {
        logic [4:0] cand;      // bit0 auth, bit1 msg, bit2 join, bit3 err, bit4 bye
        logic [2:0] phase;     // token number within the layout
        logic [2:0] kpos;      // characters of the keyword matched so far
        logic       in_token;  // within a token
        logic       nonempty;  // final parameter has seen a byte
        logic       closed;    // final parameter ended by CR or LF, or text ended by a zero byte
        logic       rejected;  // shape is wrong
    } cls_state_t;

    localparam cls_state_t STATE_RESET = {5'h1F, 3'd0, 3'd0, 4'b0000};
    localparam logic [2:0] MAX_TOKENS  = 3'd6;
    localparam logic [2:0] BYE_LEN     = 3'd3;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_B     = 8'h42;

    // ascii upper case
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_crlf(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

    // single remaining kind, else none
    function automatic kind_t kind_of(input logic [4:0] cand);
        kind_t k;
        unique case (cand)
            5'b00001: k = KIND_AUTH;
            5'b00010: k = KIND_MSG;
            5'b00100: k = KIND_JOIN;
            5'b01000: k = KIND_ERR;
            5'b10000: k = KIND_BYE;
            default:  k = KIND_NONE;
        endcase
        return k;
    endfunction

    // first letter of each kind's opening keyword, by candidate bit
    function automatic logic [7:0] first_char(input logic [2:0] i);
        logic [7:0] c;
        unique case (i)
            3'd0:    c = 8'h41;  // A
            3'd1:    c = 8'h4D;  // M
            3'd2:    c = 8'h4A;  // J
            3'd3:    c = 8'h45;  // E
            3'd4:    c = 8'h42;  // B
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [3:0] kw);
        logic [2:0] n;
        unique case (kw)
            KW_AUTH:  n = 3'd4;
            KW_AS:    n = 3'd2;
            KW_USING: n = 3'd5;
            KW_JOIN:  n = 3'd4;
            KW_MSG:   n = 3'd3;
            KW_FROM:  n = 3'd4;
            KW_IS:    n = 3'd2;
            KW_ERR:   n = 3'd3;
            KW_BYE:   n = 3'd3;
            default:  n = 3'd0;
        endcase
        return n;
    endfunction

    // one character of a keyword, zero past its end
    function automatic logic [7:0] kw_char(input logic [3:0] kw, input logic [2:0] pos);
        logic [39:0] txt;
        logic [7:0]  c;
        unique case (kw)
            KW_AUTH:  txt = {"AUTH", 8'h00};
            KW_AS:    txt = {"AS", 24'h0};
            KW_USING: txt = "USING";
            KW_JOIN:  txt = {"JOIN", 8'h00};
            KW_MSG:   txt = {"MSG", 16'h0};
            KW_FROM:  txt = {"FROM", 8'h00};
            KW_IS:    txt = {"IS", 24'h0};
            KW_ERR:   txt = {"ERR", 16'h0};
            KW_BYE:   txt = {"BYE", 16'h0};
            default:  txt = 40'h0;
        endcase
        case (pos)
            3'd0:    c = txt[39:32];
            3'd1:    c = txt[31:24];
            3'd2:    c = txt[23:16];
            3'd3:    c = txt[15:8];
            3'd4:    c = txt[7:0];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // token sequence of the four space-separated kinds
    function automatic tok_t layout(input kind_t k, input logic [2:0] ph);
        tok_t t;
        t = '{ty: TOK_TAIL, arg: 4'd2};
        case (k)
            KIND_AUTH:
            begin
                case (ph)
                    3'd0:    t = '{ty: TOK_KW,    arg: KW_AUTH};
                    3'd1:    t = '{ty: TOK_PARAM, arg: 4'd1};
                    3'd2:    t = '{ty: TOK_KW,    arg: KW_AS};
                    3'd3:    t = '{ty: TOK_PARAM, arg: 4'd2};
                    3'd4:    t = '{ty: TOK_KW,    arg: KW_USING};
                    default: t = '{ty: TOK_TAIL,  arg: 4'd3};
                endcase
            end
            KIND_MSG, KIND_ERR:
            begin
                case (ph)
                    3'd0:    t = '{ty: TOK_KW, arg: (k == KIND_MSG) ? KW_MSG : KW_ERR};
                    3'd1:    t = '{ty: TOK_KW,    arg: KW_FROM};
                    3'd2:    t = '{ty: TOK_PARAM, arg: 4'd1};
                    3'd3:    t = '{ty: TOK_KW,    arg: KW_IS};
                    default: t = '{ty: TOK_TAIL,  arg: 4'd2};
                endcase
            end
            KIND_JOIN:
            begin
                case (ph)
                    3'd0:    t = '{ty: TOK_KW,    arg: KW_JOIN};
                    3'd1:    t = '{ty: TOK_PARAM, arg: 4'd1};
                    3'd2:    t = '{ty: TOK_KW,    arg: KW_AS};
                    default: t = '{ty: TOK_TAIL,  arg: 4'd2};
                endcase
            end
            default: t = '{ty: TOK_TAIL, arg: 4'd2};
        endcase
        return t;
    endfunction

    // whether the text may end in this state
    function automatic logic accept_at_end(input cls_state_t s);
        kind_t k;
        tok_t  t;
        logic  ok;
        k  = kind_of(s.cand);
        t  = layout(k, s.phase);
        ok = 1'b0;
        if (k == KIND_BYE)
        begin
            ok = (s.phase == 3'd1) || (s.in_token && s.kpos == BYE_LEN);
        end
        else if (k != KIND_NONE && s.phase < MAX_TOKENS)
        begin
            ok = (t.ty == TOK_TAIL) && s.nonempty;
        end
        return ok;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/ccc_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_step: per-byte classification logic
// Combinational next-state, parameter tag and verdict for one message byte.
// ----------------------------------------------------------------------------
module ccc_step
    import ccc_pkg::*;
(
    input  cls_state_t state,
    input  logic [7:0] msg_byte,
    input  logic       last,
    output cls_state_t state_next,
    output logic [1:0] param_index,
    output kind_t      cmd_kind
);

    cls_state_t s;
    kind_t      k;
    tok_t       tok;
    logic [7:0] up;
    logic       crlf;
    logic       sp;
    logic [4:0] keep;
    logic [1:0] idx;
    kind_t      mtype;

    // candidate filter on the first letter
    always_comb
    begin
        up = upcase(msg_byte);
        for (int i = 0; i < 5; i++)
        begin
            keep[i] = state.cand[i] && (up == first_char(3'(i)));
        end
    end

    // state update for one byte
    always_comb
    begin
        s     = state;
        idx   = 2'd0;
        mtype = KIND_NONE;
        k     = kind_of(state.cand);
        tok   = layout(k, state.phase);
        crlf  = is_crlf(msg_byte);
        sp    = (msg_byte == CH_SPACE);

        if (!state.rejected && !state.closed)
        begin
            if (msg_byte == CH_NUL)
            begin
                // zero byte ends the text
                if (accept_at_end(state))
                    s.closed = 1'b1;
                else
                    s.rejected = 1'b1;
            end
            else if (k == KIND_NONE)
            begin
                // still choosing the kind
                if (sp)
                begin
                    s.cand[4] = 1'b0;
                end
                else if (crlf)
                begin
                    if (state.cand[4])
                        s.cand = 5'b10000;
                    else
                        s.rejected = 1'b1;
                end
                else if (keep == 5'b0)
                begin
                    s.rejected = 1'b1;
                end
                else
                begin
                    s.cand     = keep;
                    s.in_token = 1'b1;
                    s.kpos     = 3'd1;
                end
            end
            else if (k == KIND_BYE)
            begin
                // bye framed only by cr and lf
                if (state.phase != 3'd0)
                begin
                    if (!crlf)
                        s.rejected = 1'b1;
                end
                else if (!state.in_token)
                begin
                    if (!crlf)
                    begin
                        if (up == CH_B)
                        begin
                            s.in_token = 1'b1;
                            s.kpos     = 3'd1;
                        end
                        else
                        begin
                            s.rejected = 1'b1;
                        end
                    end
                end
                else if (crlf)
                begin
                    if (state.kpos == BYE_LEN)
                    begin
                        s.phase    = 3'd1;
                        s.in_token = 1'b0;
                    end
                    else
                    begin
                        s.rejected = 1'b1;
                    end
                end
                else if (state.kpos < BYE_LEN && up == kw_char(KW_BYE, state.kpos))
                begin
                    s.kpos = state.kpos + 3'd1;
                end
                else
                begin
                    s.rejected = 1'b1;
                end
            end
            else if (state.phase >= MAX_TOKENS)
            begin
                s.rejected = 1'b1;
            end
            else if (tok.ty == TOK_TAIL)
            begin
                // final parameter runs to cr or lf
                if (crlf)
                begin
                    if (state.nonempty)
                        s.closed = 1'b1;
                end
                else
                begin
                    s.nonempty = 1'b1;
                    idx        = tok.arg[1:0];
                end
            end
            else if (!state.in_token && sp)
            begin
                // skip separator run
            end
            else
            begin
                if (!state.in_token)
                begin
                    s.in_token = 1'b1;
                    s.kpos     = 3'd0;
                end
                if (sp)
                begin
                    if (tok.ty == TOK_KW && s.kpos != kw_len(tok.arg))
                    begin
                        s.rejected = 1'b1;
                    end
                    else
                    begin
                        s.in_token = 1'b0;
                        s.kpos     = 3'd0;
                        s.phase    = state.phase + 3'd1;
                    end
                end
                else if (tok.ty == TOK_PARAM)
                begin
                    idx = tok.arg[1:0];
                end
                else if (s.kpos < kw_len(tok.arg) && up == kw_char(tok.arg, s.kpos))
                begin
                    s.kpos = s.kpos + 3'd1;
                end
                else
                begin
                    s.rejected = 1'b1;
                end
            end
        end

        // end of message: close text, give verdict, start over
        if (last)
        begin
            if (!s.rejected && !s.closed)
            begin
                if (accept_at_end(s))
                    s.closed = 1'b1;
                else
                    s.rejected = 1'b1;
            end
            if (!s.rejected && s.closed)
                mtype = kind_of(s.cand);
            s = STATE_RESET;
        end

        state_next  = s;
        param_index = idx;
        cmd_kind    = mtype;
    end

endmodule
`default_nettype wire

### hw/rtl/chat_command_classifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chat_command_classifier: streaming chat command classifier
// Tags each message byte with its parameter number and gives the command
// kind on the last byte of the message.
//
//   channel  direction  handshake              word
//   input    in         in_valid / in_ready    msg_byte, last
//   output   out        out_valid / out_ready  param_index, param_byte,
//                                              is_last, cmd_kind
//
// One byte per cycle sustained while out_ready stays high; an accepted byte
// passes through the input register, then the result register, to the output.
// The parser state advances as a byte moves into the result register.
// While out_ready is low the result register holds; an empty input
// register still takes one byte, then in_ready drops.
// Reset clears both valid flags and returns the parser to its start state.
// ----------------------------------------------------------------------------
module chat_command_classifier
    import ccc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] msg_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [1:0]      param_index,
    output logic [7:0]      param_byte,
    output logic            is_last,
    output logic [2:0]      cmd_kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [1:0] param_index_reg;
    logic [7:0] param_byte_reg;
    logic       is_last_reg;
    kind_t      cmd_kind_reg;
    cls_state_t state_reg;
    cls_state_t state_next;
    logic [1:0] idx_next;
    kind_t      type_next;
    logic       out_free;
    logic       advance;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || out_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_byte_reg <= msg_byte;
            in_last_reg <= last;
        end
    end

    // classification of the held byte
    ccc_step u_step (
        .state       (state_reg),
        .msg_byte    (in_byte_reg),
        .last        (in_last_reg),
        .state_next  (state_next),
        .param_index (idx_next),
        .cmd_kind    (type_next)
    );

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            param_index_reg <= idx_next;
            param_byte_reg  <= in_byte_reg;
            is_last_reg     <= in_last_reg;
            cmd_kind_reg    <= type_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign param_index = param_index_reg;
    assign param_byte  = param_byte_reg;
    assign is_last     = is_last_reg;
    assign cmd_kind    = cmd_kind_reg;

endmodule
`default_nettype wire

### hw/rtl/ccc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccc_checker: port-level checks for the chat command classifier
// Watches the top-level ports and flags results that break the classifier's
// output rules.
// ----------------------------------------------------------------------------
module ccc_checker
    import ccc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] param_index,
    input wire logic [7:0] param_byte,
    input wire logic       is_last,
    input wire logic [2:0] cmd_kind
);

    // verdict only on the closing word
    a_type_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_last |-> cmd_kind == KIND_NONE)
        else $error("verdict on a word that does not close the message");

    // verdict code in range
    a_type_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cmd_kind <= KIND_BYE)
        else $error("verdict code out of range");

    // a zero byte ends the text and is never tagged
    a_nul_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && param_index != 2'd0 |-> param_byte != CH_NUL)
        else $error("zero byte tagged as parameter");

    // bye carries no parameters
    a_bye_untagged: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cmd_kind == KIND_BYE |-> param_index == 2'd0)
        else $error("bye verdict on a tagged word");

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(param_byte)
            && $stable(param_index) && $stable(is_last) && $stable(cmd_kind))
        else $error("output word changed while stalled");

endmodule

bind chat_command_classifier ccc_checker u_ccc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .param_index (param_index),
    .param_byte  (param_byte),
    .is_last     (is_last),
    .cmd_kind    (cmd_kind)
);
`default_nettype wire
